FILE: hw/rtl/rpsr_pkg.sv
package rpsr_pkg;

    // Fixed field widths
    localparam int DATA_W = 8;  // bit_values / erased_mask / column word
    localparam int DSK_W  = 4;  // disk_count register
    localparam int PD_W   = 3;  // parity disk index
    localparam int CNT_W  = 6;  // block_bits register, column count
    localparam int IDX_W  = 5;  // column index within a block
    localparam int NIB_W  = 4;
    localparam int CFG_IDX_W = 2;

    // Parameter defaults
    localparam int DISKS_DEF      = 8;
    localparam int MAX_BB_DEF     = 32;

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PARITY_ODD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISK_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd2;

    // One closed block, waiting to be unloaded
    typedef struct packed {
        logic              bank;
        logic [CNT_W-1:0]  ncols;
        logic [PD_W-1:0]   pdisk;
        logic [DSK_W-1:0]  disks;
        logic              last;
        logic              err;
    } t_job;

    // Column store write
    typedef struct packed {
        logic              en;
        logic              bank;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] data;
    } t_colwr;

    // Back side is done reading a bank
    typedef struct packed {
        logic valid;
        logic bank;
    } t_release;

endpackage

FILE: hw/rtl/rpsr_colmem.sv
module rpsr_colmem #(
    parameter int DISKS          = rpsr_pkg::DISKS_DEF,
    parameter int MAX_BLOCK_BITS = rpsr_pkg::MAX_BB_DEF
) (
    input  logic                         i_clk,
    input  rpsr_pkg::t_colwr             i_wr,
    input  logic                         i_rd_en,
    input  logic                         i_rd_bank,
    input  logic [rpsr_pkg::IDX_W-1:0]   i_rd_idx,
    output logic [DISKS-1:0]             o_rd_data
);

    localparam int IW    = (MAX_BLOCK_BITS > 1) ? $clog2(MAX_BLOCK_BITS) : 1;
    localparam int DEPTH = 2 ** (IW + 1);

    // two banks of repaired columns, one being filled, one being unloaded
    logic [DISKS-1:0] r_mem [DEPTH];
    logic [DISKS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[{i_wr.bank, i_wr.idx[IW-1:0]}] <= i_wr.data[DISKS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[{i_rd_bank, i_rd_idx[IW-1:0]}];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/rpsr_front.sv
module rpsr_front #(
    parameter int DISKS          = rpsr_pkg::DISKS_DEF,
    parameter int MAX_BLOCK_BITS = rpsr_pkg::MAX_BB_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // incoming columns
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [rpsr_pkg::DATA_W-1:0]   i_bits,
    input  logic [rpsr_pkg::DATA_W-1:0]   i_erased,
    input  logic                          i_last,
    // configuration
    input  logic                          i_parity_odd,
    input  logic [rpsr_pkg::DSK_W-1:0]    i_disk_count,
    input  logic [rpsr_pkg::CNT_W-1:0]    i_block_bits,
    // column store and job queue
    output rpsr_pkg::t_colwr              o_wr,
    output logic                          o_push,
    output rpsr_pkg::t_job                o_job,
    input  logic                          i_q_full,
    input  rpsr_pkg::t_release            i_release
);

    localparam int DSK_W = rpsr_pkg::DSK_W;
    localparam int CNT_W = rpsr_pkg::CNT_W;
    localparam int PD_W  = rpsr_pkg::PD_W;
    localparam int IDX_W = rpsr_pkg::IDX_W;

    logic [IDX_W-1:0] r_colidx;
    logic [PD_W-1:0]  r_pdisk;
    logic             r_err;
    logic             r_wbank;
    logic [1:0]       r_busy;
    logic [1:0]       n_busy;

    logic [DSK_W-1:0] disks;
    logic [CNT_W-1:0] bbits;
    logic [DISKS-1:0] dmask;
    logic [DISKS-1:0] er;
    logic [DISKS-1:0] intact;
    logic [DISKS-1:0] col;
    logic [DSK_W-1:0] n_erased;
    logic             par;
    logic             err_now;
    logic             accept;
    logic [CNT_W-1:0] ncols;
    logic             close_blk;
    logic [DSK_W-1:0] pinc;

    // clamp configuration into the supported range
    always_comb begin
        if (i_disk_count < DSK_W'(2)) begin
            disks = DSK_W'(2);
        end else if (i_disk_count > DSK_W'(DISKS)) begin
            disks = DSK_W'(DISKS);
        end else begin
            disks = i_disk_count;
        end
        if (i_block_bits == '0) begin
            bbits = CNT_W'(1);
        end else if (i_block_bits > CNT_W'(MAX_BLOCK_BITS)) begin
            bbits = CNT_W'(MAX_BLOCK_BITS);
        end else begin
            bbits = i_block_bits;
        end
    end

    // disks in use
    always_comb begin
        for (int i = 0; i < DISKS; i++) begin
            dmask[i] = (DSK_W'(i) < disks);
        end
    end

    // parity check and single-erasure repair
    assign er       = i_erased[DISKS-1:0] & dmask;
    assign intact   = i_bits[DISKS-1:0] & dmask & ~er;
    assign n_erased = DSK_W'($countones(er));
    assign par      = ^intact;
    assign err_now  = (n_erased >= DSK_W'(2)) ||
                      ((n_erased == '0) && (par != i_parity_odd));
    assign col      = intact | ({DISKS{i_parity_odd ^ par}} & er);

    // a bank can be refilled only once the back side let go of it
    assign o_ready   = !r_busy[r_wbank] && !i_q_full;
    assign accept    = i_valid && o_ready;
    assign ncols     = {1'b0, r_colidx} + CNT_W'(1);
    assign close_blk = (ncols >= bbits) || i_last;
    assign pinc      = {1'b0, r_pdisk} + DSK_W'(1);

    assign o_wr.en   = accept;
    assign o_wr.bank = r_wbank;
    assign o_wr.idx  = r_colidx;
    assign o_wr.data = rpsr_pkg::DATA_W'(col);

    assign o_push      = accept && close_blk;
    assign o_job.bank  = r_wbank;
    assign o_job.ncols = ncols;
    assign o_job.pdisk = r_pdisk;
    assign o_job.disks = disks;
    assign o_job.last  = i_last;
    assign o_job.err   = r_err | err_now;

    // bank ownership
    always_comb begin
        n_busy = r_busy;
        if (i_release.valid) begin
            n_busy[i_release.bank] = 1'b0;
        end
        if (o_push) begin
            n_busy[r_wbank] = 1'b1;
        end
    end

    // block position, rotating parity disk and sticky error
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_colidx <= '0;
            r_pdisk  <= '0;
            r_err    <= 1'b0;
            r_wbank  <= 1'b0;
            r_busy   <= '0;
        end else begin
            r_busy <= n_busy;
            if (accept) begin
                if (close_blk) begin
                    r_colidx <= '0;
                    r_wbank  <= !r_wbank;
                    // set end restarts the rotation
                    if (i_last) begin
                        r_pdisk <= '0;
                    end else begin
                        r_pdisk <= (pinc >= disks) ? '0 : pinc[PD_W-1:0];
                    end
                end else begin
                    r_colidx <= ncols[IDX_W-1:0];
                end
                if (i_last) begin
                    r_err   <= 1'b0;
                end else begin
                    r_err   <= r_err | err_now;
                end
            end
        end
    end

endmodule

FILE: hw/rtl/rpsr_queue.sv
module rpsr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rpsr_pkg::t_job i_job,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output rpsr_pkg::t_job o_job
);

    localparam int QPTR_W = rpsr_pkg::QPTR_W;
    localparam int QCNT_W = rpsr_pkg::QCNT_W;

    rpsr_pkg::t_job      r_slot [rpsr_pkg::QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wp;
    logic [QPTR_W-1:0]   r_rp;
    logic [QCNT_W-1:0]   r_cnt;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_cnt == QCNT_W'(rpsr_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_slot[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_job;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

endmodule

FILE: hw/rtl/rpsr_back.sv
module rpsr_back #(
    parameter int DISKS = rpsr_pkg::DISKS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // job queue
    input  logic                          i_job_valid,
    input  rpsr_pkg::t_job                i_job,
    output logic                          o_pop,
    // column store read port
    output logic                          o_rd_en,
    output logic                          o_rd_bank,
    output logic [rpsr_pkg::IDX_W-1:0]    o_rd_idx,
    input  logic [DISKS-1:0]              i_rd_data,
    output rpsr_pkg::t_release            o_release,
    // results
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [rpsr_pkg::NIB_W-1:0]    o_nibble,
    output logic                          o_nibble_valid,
    output logic                          o_set_invalid,
    output logic                          o_end_of_set
);

    localparam int DW    = $clog2(DISKS);
    localparam int DSK_W = rpsr_pkg::DSK_W;
    localparam int CNT_W = rpsr_pkg::CNT_W;
    localparam int NIB_W = rpsr_pkg::NIB_W;

    // walker: one (disk, column) pair per cycle while the bit stage is not stalled
    logic                 r_active;
    rpsr_pkg::t_job       r_job;
    logic [DSK_W-1:0]     r_j;
    logic [CNT_W-1:0]     r_k;

    // bit stage, aligned with the registered read data
    logic                 r_b_valid;
    logic [DSK_W-1:0]     r_b_disk;
    logic                 r_b_final;
    logic                 r_b_last;
    logic                 r_b_err;

    // nibble assembly and end-of-set flush
    logic [2:0]           r_pbits;
    logic [1:0]           r_pcnt;
    logic                 r_flush;
    logic                 r_flush_err;

    // output register
    logic                 r_out_valid;
    logic [NIB_W-1:0]     r_out_nib;
    logic                 r_out_nv;
    logic                 r_out_err;
    logic                 r_out_end;

    logic                 out_free;
    logic                 need_out;
    logic                 b_go;
    logic                 issue;
    logic                 flush_go;
    logic                 bit_v;
    logic                 last_k;
    logic                 job_done;
    logic [CNT_W-1:0]     k_inc;
    logic [DSK_W-1:0]     j_inc;
    logic [DSK_W-1:0]     j_next;
    logic [DSK_W-1:0]     j_first;
    logic [NIB_W-1:0]     flush_nib;

    assign out_free = !r_out_valid || i_ready;
    assign bit_v    = i_rd_data[r_b_disk[DW-1:0]];
    assign need_out = (r_pcnt == 2'd3);
    assign b_go     = r_b_valid && !r_flush && (!need_out || out_free);
    assign issue    = r_active && (!r_b_valid || b_go);
    assign flush_go = r_flush && out_free;
    assign o_pop    = !r_active && i_job_valid;

    // next position, skipping the parity disk
    assign k_inc    = r_k + CNT_W'(1);
    assign last_k   = (k_inc == r_job.ncols);
    assign j_inc    = r_j + DSK_W'(1);
    assign j_next   = (j_inc == {1'b0, r_job.pdisk}) ? r_j + DSK_W'(2) : j_inc;
    assign job_done = last_k && (j_next >= r_job.disks);
    assign j_first  = (i_job.pdisk == '0) ? DSK_W'(1) : '0;

    assign o_rd_en   = issue;
    assign o_rd_bank = r_job.bank;
    assign o_rd_idx  = r_k[rpsr_pkg::IDX_W-1:0];

    assign o_release.valid = issue && job_done;
    assign o_release.bank  = r_job.bank;

    // zero-padded leftover bits
    always_comb begin
        unique case (r_pcnt)
            2'd0:    flush_nib = '0;
            2'd1:    flush_nib = {r_pbits[0], 3'b000};
            2'd2:    flush_nib = {r_pbits[1:0], 2'b00};
            2'd3:    flush_nib = {r_pbits, 1'b0};
            default: flush_nib = '0;
        endcase
    end

    // walker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (o_pop) begin
            r_active <= 1'b1;
            r_job    <= i_job;
            r_j      <= j_first;
            r_k      <= '0;
        end else if (issue) begin
            if (job_done) begin
                r_active <= 1'b0;
            end else if (last_k) begin
                r_k <= '0;
                r_j <= j_next;
            end else begin
                r_k <= k_inc;
            end
        end
    end

    // bit stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (issue) begin
            r_b_valid <= 1'b1;
            r_b_disk  <= r_j;
            r_b_final <= job_done;
            r_b_last  <= r_job.last;
            r_b_err   <= r_job.err;
        end else if (b_go) begin
            r_b_valid <= 1'b0;
        end
    end

    // nibble assembly and flush request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pbits <= '0;
            r_pcnt  <= '0;
            r_flush <= 1'b0;
        end else if (b_go) begin
            if (need_out) begin
                r_pbits <= '0;
                r_pcnt  <= '0;
            end else begin
                r_pbits <= {r_pbits[1:0], bit_v};
                r_pcnt  <= r_pcnt + 2'd1;
            end
            if (r_b_final && r_b_last) begin
                r_flush     <= 1'b1;
                r_flush_err <= r_b_err;
            end
        end else if (flush_go) begin
            r_pbits <= '0;
            r_pcnt  <= '0;
            r_flush <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (b_go && need_out) begin
            r_out_valid <= 1'b1;
            r_out_nib   <= {r_pbits, bit_v};
            r_out_nv    <= 1'b1;
            r_out_err   <= r_b_err;
            r_out_end   <= 1'b0;
        end else if (flush_go) begin
            r_out_valid <= 1'b1;
            r_out_nib   <= flush_nib;
            r_out_nv    <= (r_pcnt != '0);
            r_out_err   <= r_flush_err;
            r_out_end   <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_nibble       = r_out_nib;
    assign o_nibble_valid = r_out_nv;
    assign o_set_invalid  = r_out_err;
    assign o_end_of_set   = r_out_end;

endmodule

FILE: hw/rtl/rotating_parity_stripe_recover.sv
// Rotating-parity stripe recovery.
// Input stream: one bit column of a stripe per item. tdata[7:0] holds one bit
// per disk (disk 0 in bit 0), tdata[15:8] the erased mask, tlast marks the
// final column of the disk set. Each column is parity checked, a single
// erased bit is rebuilt, and the column is buffered in one of two banks.
// When a block closes (block_bits columns, or tlast) the data disks are
// unloaded disk by disk, skipping the rotating parity disk, as 4-bit nibbles.
// Output stream: tdata[3:0] nibble, tuser[0] nibble valid, tuser[1] sticky
// set error, tlast on the final result of the set (zero-padded leftover).
// Unloading: the unloader reads the column store once per data bit of a
// block. The input side fills one bank while the other drains, so it stalls
// only when both banks hold unfinished blocks. Latency: with no leftover
// bits pending, the first nibble of a block goes from its closing column
// through the job queue, the walker, the column store read, the bit stage
// and nibble assembly to the output register; leftover bits of an earlier
// block let it appear sooner, a block still draining ahead of it delays it.
// Reset clears all control state and the configuration (even parity, two
// disks, one bit per block). A stalled receiver holds the output register and
// backs up through the unloader and the job queue to the input side.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_wdata.
module rotating_parity_stripe_recover #(
    parameter int DISKS          = rpsr_pkg::DISKS_DEF,
    parameter int MAX_BLOCK_BITS = rpsr_pkg::MAX_BB_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_we,
    input  logic [rpsr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rpsr_pkg::CNT_W-1:0]       i_cfg_wdata,
    // columns in
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [15:0]                      s_axis_tdata,  // bit_values, erased_mask
    input  logic                             s_axis_tlast,  // last_in_set
    // nibbles out
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [7:0]                       m_axis_tdata,  // hex_nibble, zero pad
    output logic [1:0]                       m_axis_tuser,  // nibble_valid, set_invalid
    output logic                             m_axis_tlast   // end_of_set
);

    localparam int DSK_W = rpsr_pkg::DSK_W;
    localparam int CNT_W = rpsr_pkg::CNT_W;
    localparam int NIB_W = rpsr_pkg::NIB_W;

    logic               r_parity_odd;
    logic [DSK_W-1:0]   r_disk_count;
    logic [CNT_W-1:0]   r_block_bits;

    rpsr_pkg::t_colwr   wr;
    rpsr_pkg::t_job     push_job;
    rpsr_pkg::t_job     head_job;
    rpsr_pkg::t_release release_bank;
    logic               push;
    logic               q_full;
    logic               q_valid;
    logic               pop;
    logic               rd_en;
    logic               rd_bank;
    logic [rpsr_pkg::IDX_W-1:0] rd_idx;
    logic [DISKS-1:0]   rd_data;
    logic [NIB_W-1:0]   nibble;
    logic               nibble_valid;
    logic               set_invalid;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parity_odd <= 1'b0;
            r_disk_count <= DSK_W'(2);
            r_block_bits <= CNT_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rpsr_pkg::CFG_PARITY_ODD: r_parity_odd <= i_cfg_wdata[0];
                rpsr_pkg::CFG_DISK_COUNT: r_disk_count <= i_cfg_wdata[DSK_W-1:0];
                rpsr_pkg::CFG_BLOCK_BITS: r_block_bits <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    rpsr_front #(
        .DISKS          (DISKS),
        .MAX_BLOCK_BITS (MAX_BLOCK_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_bits       (s_axis_tdata[7:0]),
        .i_erased     (s_axis_tdata[15:8]),
        .i_last       (s_axis_tlast),
        .i_parity_odd (r_parity_odd),
        .i_disk_count (r_disk_count),
        .i_block_bits (r_block_bits),
        .o_wr         (wr),
        .o_push       (push),
        .o_job        (push_job),
        .i_q_full     (q_full),
        .i_release    (release_bank)
    );

    rpsr_colmem #(
        .DISKS          (DISKS),
        .MAX_BLOCK_BITS (MAX_BLOCK_BITS)
    ) u_colmem (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_en   (rd_en),
        .i_rd_bank (rd_bank),
        .i_rd_idx  (rd_idx),
        .o_rd_data (rd_data)
    );

    rpsr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_job   (head_job)
    );

    rpsr_back #(
        .DISKS (DISKS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (q_valid),
        .i_job          (head_job),
        .o_pop          (pop),
        .o_rd_en        (rd_en),
        .o_rd_bank      (rd_bank),
        .o_rd_idx       (rd_idx),
        .i_rd_data      (rd_data),
        .o_release      (release_bank),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_nibble       (nibble),
        .o_nibble_valid (nibble_valid),
        .o_set_invalid  (set_invalid),
        .o_end_of_set   (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0000, nibble};
    assign m_axis_tuser = {set_invalid, nibble_valid};

endmodule
